>>> hw/rtl/mwse_pkg.sv
// ----------------------------------------------------------------------------
// mwse_pkg
// Shared types, constants and the UTF-8 encode function of the metaspace
// word split encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mwse_pkg;

  localparam int CP_W    = 21;
  localparam int MAX_RES = 9;
  localparam int CNT_W   = 4;

  localparam logic [CP_W-1:0] SPACE_CP     = 21'h000020;
  localparam logic [CP_W-1:0] FALLBACK_CP  = 21'h00FFFD;
  localparam logic [CP_W-1:0] MAX_CP       = 21'h10FFFF;
  localparam logic [CP_W-1:0] REP_RESET    = 21'd9601;

  typedef enum logic [1:0] {
    MODE_ALWAYS       = 2'd0,
    MODE_UNLESS_SPACE = 2'd1,
    MODE_NEVER        = 2'd2
  } prepend_mode_t;

  typedef enum logic [1:0] {
    REG_REPLACEMENT = 2'd0,
    REG_PREPEND     = 2'd1,
    REG_SPLIT       = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    CHUNK_NONE = 2'd0,
    CHUNK_MARK = 2'd1,
    CHUNK_REP  = 2'd2
  } chunk_kind_t;

  typedef struct packed {
    logic [CP_W-1:0] replacement_char;
    logic [1:0]      prepend_mode;
    logic            split_words;
  } cfg_t;

  typedef struct packed {
    logic [CP_W-1:0] codepoint;
    logic            first_of_text;
    logic            last_of_text;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       segment_end;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] ent;
    logic [CNT_W-1:0]   cnt;
  } plan_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } utf8_t;

  function automatic utf8_t utf8_enc(input logic [CP_W-1:0] cp_in);
    logic [CP_W-1:0] c;
    utf8_t           r;
    c   = (cp_in > MAX_CP) ? FALLBACK_CP : cp_in;
    r.b = '0;
    if (c < 21'h80) begin
      r.b[0] = c[7:0];
      r.n    = 3'd1;
    end else if (c < 21'h800) begin
      r.b[0] = {3'b110, c[10:6]};
      r.b[1] = {2'b10, c[5:0]};
      r.n    = 3'd2;
    end else if (c < 21'h10000) begin
      r.b[0] = {4'b1110, c[15:12]};
      r.b[1] = {2'b10, c[11:6]};
      r.b[2] = {2'b10, c[5:0]};
      r.n    = 3'd3;
    end else begin
      r.b[0] = {5'b11110, c[20:18]};
      r.b[1] = {2'b10, c[17:12]};
      r.b[2] = {2'b10, c[11:6]};
      r.b[3] = {2'b10, c[5:0]};
      r.n    = 3'd4;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/metaspace_word_split_encoder_top.sv
// ----------------------------------------------------------------------------
// metaspace_word_split_encoder_top
// Replaces spaces by a replacement codepoint, encodes UTF-8 bytes and cuts
// the byte stream into word segments, or into text segments when split_words is clear.
//
//   channel | direction | payload
//   s_axis  | in        | tdata[20:0] codepoint, tuser first_of_text, tlast last
//   m_axis  | out       | tdata[7:0] byte, tuser byte_present/last_of_item,
//           |           | tlast segment_end
//   apb     | in/out    | 0 replacement_char, 4 prepend_mode, 8 split_words
//
// One codepoint causes zero to nine results (usually one to four), held in
// the byte-serial result register and sent out in order; an item with no
// result is taken all the same. The input register takes the next codepoint
// while results still drain. Stalls on m_tready hold the result register and,
// once the input register is full, drop s_tready. Reset is synchronous.
// ----------------------------------------------------------------------------
`default_nettype none

module metaspace_word_split_encoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [20:0] codepoint, [23:21] zero
  input  wire logic        s_tlast,
  input  wire logic [0:0]  s_tuser,   // [0] first_of_text
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [7:0] out_byte
  output logic             m_tlast,
  output logic [1:0]       m_tuser,   // [0] byte_present, [1] last_of_item
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import mwse_pkg::*;

  cfg_t  cfg;
  item_t item;
  plan_t plan;
  logic  in_vld;
  logic  load;

  mwse_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg
  );

  mwse_in_reg u_in (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tlast, .s_tuser,
    .take(load), .vld(in_vld), .item
  );

  mwse_planner u_plan (
    .clk, .rst, .cfg, .item, .load, .plan
  );

  mwse_serializer u_ser (
    .clk, .rst, .in_vld, .plan, .load,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast, .m_tuser
  );

endmodule

`default_nettype wire

>>> hw/rtl/mwse_cfg.sv
// ----------------------------------------------------------------------------
// mwse_cfg
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module mwse_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output mwse_pkg::cfg_t     cfg
);
  import mwse_pkg::*;

  logic       wr;
  reg_index_t idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign idx    = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.replacement_char <= REP_RESET;
      cfg.prepend_mode     <= MODE_ALWAYS;
      cfg.split_words      <= 1'b1;
    end else if (wr) begin
      unique case (idx)
        REG_REPLACEMENT: cfg.replacement_char <= pwdata[CP_W-1:0];
        REG_PREPEND:     cfg.prepend_mode     <= pwdata[1:0];
        REG_SPLIT:       cfg.split_words      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_REPLACEMENT: prdata = {11'd0, cfg.replacement_char};
      REG_PREPEND:     prdata = {30'd0, cfg.prepend_mode};
      REG_SPLIT:       prdata = {31'd0, cfg.split_words};
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/mwse_in_reg.sv
// ----------------------------------------------------------------------------
// mwse_in_reg
// Input register: holds one codepoint transfer until the planner takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mwse_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [23:0]   s_tdata,
  input  wire logic          s_tlast,
  input  wire logic [0:0]    s_tuser,
  input  wire logic          take,
  output logic               vld,
  output mwse_pkg::item_t    item
);
  import mwse_pkg::*;

  logic vld_next;

  assign s_tready = !vld || take;

  always_comb begin
    vld_next = vld;
    if (take) vld_next = 1'b0;
    if (s_tvalid && s_tready) vld_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.codepoint     <= s_tdata[CP_W-1:0];
      item.first_of_text <= s_tuser[0];
      item.last_of_text  <= s_tlast;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mwse_planner.sv
// ----------------------------------------------------------------------------
// mwse_planner
// Word state and the result list of one codepoint: an optional replacement
// or marker, the optional codepoint bytes, and an optional closing marker.
// ----------------------------------------------------------------------------
`default_nettype none

module mwse_planner (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mwse_pkg::cfg_t  cfg,
  input  wire mwse_pkg::item_t item,
  input  wire logic          load,
  output mwse_pkg::plan_t    plan
);
  import mwse_pkg::*;

  logic        inside_word, inside_word_next;
  logic        replacement_pending, replacement_pending_next;
  logic        cp_is_blank, prepend, iw0, pend1;
  chunk_kind_t a_kind;
  logic        a_end, b_on, b_end, c_on;
  utf8_t       ua, ub;
  logic [CNT_W-1:0] na, nb, nc;

  assign cp_is_blank = (item.codepoint == SPACE_CP);
  assign prepend  = item.first_of_text &&
                    ((cfg.prepend_mode == MODE_ALWAYS) ||
                     ((cfg.prepend_mode == MODE_UNLESS_SPACE) && !cp_is_blank));
  assign iw0      = item.first_of_text ? 1'b0 : inside_word;
  assign pend1    = (item.first_of_text ? 1'b0 : replacement_pending) | prepend;
  assign ua       = utf8_enc(cfg.replacement_char);
  assign ub       = utf8_enc(cp_is_blank ? cfg.replacement_char : item.codepoint);

  always_comb begin
    a_kind                   = CHUNK_NONE;
    a_end                    = 1'b0;
    b_on                     = 1'b0;
    b_end                    = 1'b0;
    c_on                     = 1'b0;
    inside_word_next         = 1'b0;
    replacement_pending_next = 1'b0;
    if (cfg.split_words) begin
      if (cp_is_blank) begin
        if (iw0) begin
          a_kind = CHUNK_MARK;
        end else if (pend1) begin
          a_kind = CHUNK_REP;
          a_end  = 1'b1;
        end
        replacement_pending_next = 1'b1;
      end else begin
        if (!iw0 && pend1) a_kind = CHUNK_REP;
        b_on             = 1'b1;
        inside_word_next = 1'b1;
      end
      if (item.last_of_text) begin
        c_on                     = inside_word_next;
        inside_word_next         = 1'b0;
        replacement_pending_next = 1'b0;
      end
    end else begin
      if (prepend) a_kind = CHUNK_REP;
      b_on  = 1'b1;
      b_end = item.last_of_text;
    end
  end

  always_comb begin
    case (a_kind)
      CHUNK_MARK: na = CNT_W'(1);
      CHUNK_REP:  na = CNT_W'(ua.n);
      default:    na = '0;
    endcase
    nb = b_on ? CNT_W'(ub.n) : '0;
    nc = c_on ? CNT_W'(1) : '0;
  end

  always_comb begin
    logic [CNT_W-1:0] k;
    logic [CNT_W-1:0] j;
    plan.cnt = na + nb + nc;
    for (int i = 0; i < MAX_RES; i++) begin
      k = CNT_W'(i);
      j = k - na;
      if (k < na) begin
        if (a_kind == CHUNK_MARK) begin
          plan.ent[i] = '{out_byte: 8'd0, byte_present: 1'b0, segment_end: 1'b1};
        end else begin
          plan.ent[i] = '{out_byte: ua.b[k[1:0]], byte_present: 1'b1,
                          segment_end: a_end && (k == na - CNT_W'(1))};
        end
      end else if (k < na + nb) begin
        plan.ent[i] = '{out_byte: ub.b[j[1:0]], byte_present: 1'b1,
                        segment_end: b_end && (j == nb - CNT_W'(1))};
      end else begin
        plan.ent[i] = '{out_byte: 8'd0, byte_present: 1'b0, segment_end: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_word         <= 1'b0;
      replacement_pending <= 1'b0;
    end else if (load) begin
      inside_word         <= inside_word_next;
      replacement_pending <= replacement_pending_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/mwse_serializer.sv
// ----------------------------------------------------------------------------
// mwse_serializer
// Result register: holds the result list of one codepoint and shifts it out
// one transfer per cycle while m_tready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module mwse_serializer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_vld,
  input  wire mwse_pkg::plan_t plan,
  output logic                 load,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [7:0]           m_tdata,
  output logic                 m_tlast,
  output logic [1:0]           m_tuser
);
  import mwse_pkg::*;

  res_t [MAX_RES-1:0] ent, ent_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic               xfer;

  assign m_tvalid = (cnt != '0);
  assign xfer     = m_tvalid && m_tready;
  assign load     = in_vld && ((cnt == '0) || ((cnt == CNT_W'(1)) && xfer));
  assign m_tdata  = ent[0].out_byte;
  assign m_tlast  = ent[0].segment_end;
  assign m_tuser  = {cnt == CNT_W'(1), ent[0].byte_present};

  always_comb begin
    ent_next = ent;
    cnt_next = cnt;
    if (load) begin
      ent_next = plan.ent;
      cnt_next = plan.cnt;
    end else if (xfer) begin
      for (int i = 0; i < MAX_RES - 1; i++) ent_next[i] = ent[i+1];
      ent_next[MAX_RES-1] = '0;
      cnt_next            = cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

`default_nettype wire

>>> hw/rtl/mwse_checker.sv
// ----------------------------------------------------------------------------
// mwse_checker
// Port-level checks of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mwse_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [23:0] s_tdata,
  input wire logic        s_tlast,
  input wire logic [0:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata,
  input wire logic        m_tlast,
  input wire logic [1:0]  m_tuser,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [3:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready
);
  import mwse_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("result transfer changed while stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser)
                              && $stable(s_tlast))
    else $error("input transfer changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> s_tready && !m_tvalid)
    else $error("encoder not empty after reset");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result pending");

  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && (paddr[3:2] == REG_PREPEND) |=>
      (paddr[3:2] != REG_PREPEND) || (prdata[1:0] == $past(pwdata[1:0])))
    else $error("prepend_mode readback mismatch");

endmodule

bind metaspace_word_split_encoder_top mwse_checker u_chk (.*);

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for metaspace_word_split_encoder_top. A stimulus table
// covers reset defaults, UTF-8 length edges, the out-of-range fallback, text
// marks and register settings. Random texts follow, one register setting
// per phase. Every byte and marker transfer is checked against the table's
// typed results or an in-bench model of space replacement, prepend and word
// splitting. Both streams idle at random.
// ----------------------------------------------------------------------------

module tb_top;
  import mwse_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int IDLE_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 16;

  typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_CHK, ROW_RES} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    reg_index_t  reg_sel;
    logic [20:0] val;
    logic        a;  // first_of_text, or byte_present on a result row
    logic        b;  // last_of_text, or segment_end on a result row
  } stim_row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       seg_end;
    logic       last;
  } out_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic [1:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  metaspace_word_split_encoder_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // model copy of registers and segment state
  logic [20:0] cfg_rep   = REP_RESET;
  logic [1:0]  cfg_mode  = MODE_ALWAYS;
  logic        cfg_split = 1'b1;
  logic        word_open = 1'b0;
  logic        rep_held  = 1'b0;

  out_byte_t   item_bytes[$];
  out_byte_t   byte_expect[$];
  out_byte_t   typed_bytes[$];
  logic        typed_on = 1'b0;
  stim_row_t   stim_tbl[$];

  int          fail_count = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          rx_left = 0;
  int          rx_mode = 0;

  function automatic void emit_cp(logic [20:0] cp_in, logic seg);
    int unsigned v;
    int          n;
    logic [7:0]  b[4];
    logic [7:0]  lead;
    v = (cp_in > MAX_CP) ? FALLBACK_CP : cp_in;
    if (v < 32'h80) begin
      n = 1; lead = 8'h00;
    end else if (v < 32'h800) begin
      n = 2; lead = 8'hC0;
    end else if (v < 32'h10000) begin
      n = 3; lead = 8'hE0;
    end else begin
      n = 4; lead = 8'hF0;
    end
    for (int i = n - 1; i > 0; i--) begin
      b[i] = 8'h80 | 8'(v & 32'h3F);
      v = v >> 6;
    end
    b[0] = lead | 8'(v);
    for (int i = 0; i < n; i++)
      item_bytes.push_back('{b[i], 1'b1, seg && (i == n - 1), 1'b0});
  endfunction

  function automatic void predict_item(logic [20:0] cp, logic first, logic last);
    logic is_sp;
    logic pre;
    is_sp = (cp == SPACE_CP);
    pre = 1'b0;
    item_bytes.delete();
    if (first) begin
      word_open = 1'b0;
      rep_held = 1'b0;
      if (cfg_mode == MODE_ALWAYS) pre = 1'b1;
      else if (cfg_mode == MODE_UNLESS_SPACE) pre = !is_sp;
    end
    if (cfg_split) begin
      if (pre) rep_held = 1'b1;
      if (is_sp) begin
        if (word_open) begin
          item_bytes.push_back('{8'h00, 1'b0, 1'b1, 1'b0});
          word_open = 1'b0;
        end else if (rep_held) begin
          emit_cp(cfg_rep, 1'b1);
        end
        rep_held = 1'b1;
      end else begin
        if (!word_open) begin
          if (rep_held) emit_cp(cfg_rep, 1'b0);
          word_open = 1'b1;
          rep_held = 1'b0;
        end
        emit_cp(cp, 1'b0);
      end
      if (last) begin
        if (word_open) item_bytes.push_back('{8'h00, 1'b0, 1'b1, 1'b0});
        word_open = 1'b0;
        rep_held = 1'b0;
      end
    end else begin
      if (pre) emit_cp(cfg_rep, 1'b0);
      emit_cp(is_sp ? cfg_rep : cp, last);
      word_open = 1'b0;
      rep_held = 1'b0;
    end
    if (item_bytes.size() > 0) item_bytes[item_bytes.size() - 1].last = 1'b1;
  endfunction

  function automatic logic [20:0] pick_cp();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) return SPACE_CP;
    if (sel < 65) return 21'($urandom_range(32'h21, 32'h7E));
    if (sel < 75) return 21'($urandom_range(32'h80, 32'h7FF));
    if (sel < 85) return 21'($urandom_range(32'h800, 32'hFFFF));
    if (sel < 92) return 21'($urandom_range(32'h10000, 32'h10FFFF));
    if (sel < 96) return 21'($urandom_range(32'h110000, 32'h1FFFFF));
    return 21'($urandom_range(0, 32'h1F));
  endfunction

  function automatic logic [20:0] pick_rep();
    case ($urandom_range(0, 8))
      0: return REP_RESET;
      1: return 21'h000000;
      2: return 21'h00007F;
      3: return 21'h000080;
      4: return 21'h0007FF;
      5: return 21'h00FFFF;
      6: return MAX_CP;
      7: return 21'h1FFFFF;
      default: return 21'($urandom_range(0, 32'h1FFFFF));
    endcase
  endfunction

  function automatic stim_row_t row_of(row_kind_t k, logic [20:0] v, logic a, logic b);
    return '{k, REG_REPLACEMENT, v, a, b};
  endfunction

  function automatic stim_row_t reg_row(reg_index_t sel, logic [20:0] v);
    return '{ROW_CFG, sel, v, 1'b0, 1'b0};
  endfunction

  task automatic note_failure(string what, out_byte_t want, out_byte_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: exp byte=%h present=%b seg_end=%b last=%b, got byte=%h present=%b seg_end=%b last=%b",
               $realtime, what, want.data, want.present, want.seg_end, want.last,
               got.data, got.present, got.seg_end, got.last);
  endtask

  // called at a falling edge; returns at a falling edge
  task automatic send_item(logic [20:0] cp, logic first, logic last);
    s_tdata = {3'b000, cp};
    s_tuser = first;
    s_tlast = last;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (burst_left == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 30);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (byte_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_write(reg_index_t sel, logic [20:0] v);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {sel, 2'b00};
    pwdata = {11'd0, v};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (sel)
      REG_REPLACEMENT: cfg_rep = v;
      REG_PREPEND:     cfg_mode = v[1:0];
      REG_SPLIT:       cfg_split = v[0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // receiver stall pattern: runs of full rate, coin flip, sparse, hard stall
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = (rx_mode == 3) ? $urandom_range(1, 20) : $urandom_range(4, 40);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    out_byte_t got;
    out_byte_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_item(s_tdata[20:0], s_tuser[0], s_tlast);
        if (typed_on) begin
          foreach (typed_bytes[k]) byte_expect.push_back(typed_bytes[k]);
        end else begin
          foreach (item_bytes[k]) byte_expect.push_back(item_bytes[k]);
        end
      end
      if (m_tvalid && m_tready) begin
        got = '{m_tdata, m_tuser[0], m_tlast, m_tuser[1]};
        if (byte_expect.size() == 0) begin
          note_failure("unexpected transfer", got, got);
        end else begin
          want = byte_expect.pop_front();
          if (got !== want) note_failure("mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("metaspace_word_split_encoder_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int          j;
    int          sent;
    int          len;
    logic        first;
    logic        last;
    logic        broken;
    logic [2:0]  ph;

    // reset defaults: split on, always prepend, U+2581
    stim_tbl.push_back(row_of(ROW_CHK, 21'h61, 1'b1, 1'b1));
    stim_tbl.push_back(row_of(ROW_RES, 21'hE2, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_RES, 21'h96, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_RES, 21'h81, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_RES, 21'h61, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_RES, 21'h00, 1'b0, 1'b1));
    // out of range codepoint falls back to U+FFFD
    stim_tbl.push_back(row_of(ROW_CHK, 21'h1FFFFF, 1'b1, 1'b1));
    stim_tbl.push_back(row_of(ROW_RES, 21'hE2, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_RES, 21'h96, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_RES, 21'h81, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_RES, 21'hEF, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_RES, 21'hBF, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_RES, 21'hBD, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_RES, 21'h00, 1'b0, 1'b1));
    // words, double space, surrogate, trailing space
    stim_tbl.push_back(row_of(ROW_ITEM, 21'h68, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_ITEM, 21'h69, 1'b0, 1'b0));
    stim_tbl.push_back(row_of(ROW_ITEM, SPACE_CP, 1'b0, 1'b0));
    stim_tbl.push_back(row_of(ROW_ITEM, SPACE_CP, 1'b0, 1'b0));
    stim_tbl.push_back(row_of(ROW_ITEM, 21'h00D800, 1'b0, 1'b0));
    stim_tbl.push_back(row_of(ROW_ITEM, SPACE_CP, 1'b0, 1'b1));
    // leading space, then UTF-8 length edges
    stim_tbl.push_back(row_of(ROW_ITEM, SPACE_CP, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_ITEM, 21'h00007F, 1'b0, 1'b0));
    stim_tbl.push_back(row_of(ROW_ITEM, 21'h000080, 1'b0, 1'b0));
    stim_tbl.push_back(row_of(ROW_ITEM, 21'h0007FF, 1'b0, 1'b0));
    stim_tbl.push_back(row_of(ROW_ITEM, 21'h000800, 1'b0, 1'b0));
    stim_tbl.push_back(row_of(ROW_ITEM, 21'h00FFFF, 1'b0, 1'b0));
    stim_tbl.push_back(row_of(ROW_ITEM, 21'h010000, 1'b0, 1'b0));
    stim_tbl.push_back(row_of(ROW_ITEM, MAX_CP, 1'b0, 1'b1));
    // text without a first mark after a finished one
    stim_tbl.push_back(row_of(ROW_ITEM, 21'h110000, 1'b0, 1'b0));
    stim_tbl.push_back(row_of(ROW_ITEM, 21'h000000, 1'b0, 1'b1));
    // lone space without prepend gives nothing
    stim_tbl.push_back(reg_row(REG_PREPEND, 21'(MODE_UNLESS_SPACE)));
    stim_tbl.push_back(row_of(ROW_CHK, SPACE_CP, 1'b1, 1'b1));
    stim_tbl.push_back(row_of(ROW_ITEM, SPACE_CP, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_ITEM, 21'h78, 1'b0, 1'b1));
    // unused prepend mode acts as never
    stim_tbl.push_back(reg_row(REG_PREPEND, 21'(MODE_UNUSED)));
    stim_tbl.push_back(row_of(ROW_CHK, 21'h61, 1'b1, 1'b1));
    stim_tbl.push_back(row_of(ROW_RES, 21'h61, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_RES, 21'h00, 1'b0, 1'b1));
    // continuous segment, out of range replacement
    stim_tbl.push_back(reg_row(REG_SPLIT, 21'd0));
    stim_tbl.push_back(reg_row(REG_REPLACEMENT, 21'h1FFFFF));
    stim_tbl.push_back(row_of(ROW_CHK, SPACE_CP, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_RES, 21'hEF, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_RES, 21'hBF, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_RES, 21'hBD, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_CHK, 21'h62, 1'b0, 1'b1));
    stim_tbl.push_back(row_of(ROW_RES, 21'h62, 1'b1, 1'b1));
    // replacement zero is a real byte, not a marker
    stim_tbl.push_back(reg_row(REG_PREPEND, 21'(MODE_ALWAYS)));
    stim_tbl.push_back(reg_row(REG_REPLACEMENT, 21'h000000));
    stim_tbl.push_back(row_of(ROW_CHK, 21'h63, 1'b1, 1'b1));
    stim_tbl.push_back(row_of(ROW_RES, 21'h00, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_RES, 21'h63, 1'b1, 1'b1));
    // most results from one item
    stim_tbl.push_back(reg_row(REG_SPLIT, 21'd1));
    stim_tbl.push_back(reg_row(REG_REPLACEMENT, MAX_CP));
    stim_tbl.push_back(row_of(ROW_CHK, 21'h010000, 1'b1, 1'b1));
    stim_tbl.push_back(row_of(ROW_RES, 21'hF4, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_RES, 21'h8F, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_RES, 21'hBF, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_RES, 21'hBF, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_RES, 21'hF0, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_RES, 21'h90, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_RES, 21'h80, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_RES, 21'h80, 1'b1, 1'b0));
    stim_tbl.push_back(row_of(ROW_RES, 21'h00, 1'b0, 1'b1));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    burst_left = $urandom_range(1, 30);

    j = 0;
    while (j < stim_tbl.size()) begin
      case (stim_tbl[j].kind)
        ROW_CFG: begin
          wait_idle();
          apb_write(stim_tbl[j].reg_sel, stim_tbl[j].val);
          j++;
        end
        ROW_CHK: begin
          typed_bytes.delete();
          j++;
          while (j < stim_tbl.size() && stim_tbl[j].kind == ROW_RES) begin
            typed_bytes.push_back('{stim_tbl[j].val[7:0], stim_tbl[j].a, stim_tbl[j].b, 1'b0});
            j++;
          end
          if (typed_bytes.size() > 0) typed_bytes[typed_bytes.size() - 1].last = 1'b1;
          typed_on = 1'b1;
          send_item(stim_tbl[j - typed_bytes.size() - 1].val,
                    stim_tbl[j - typed_bytes.size() - 1].a,
                    stim_tbl[j - typed_bytes.size() - 1].b);
          typed_on = 1'b0;
        end
        default: begin
          send_item(stim_tbl[j].val, stim_tbl[j].a, stim_tbl[j].b);
          j++;
        end
      endcase
    end

    // random texts, one register setting per phase
    for (int p = 0; p < PHASES; p++) begin
      ph = 3'(p);
      wait_idle();
      apb_write(REG_REPLACEMENT, pick_rep());
      apb_write(REG_PREPEND, {19'd0, ph[1:0]});
      apb_write(REG_SPLIT, {20'd0, ph[2] ^ ph[0]});
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = $urandom_range(1, 8);
        broken = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < len; k++) begin
          first = (k == 0);
          last = (k == len - 1);
          if (broken) begin
            first = 1'($urandom_range(0, 1));
            last = 1'($urandom_range(0, 1));
          end
          send_item(pick_cp(), first, last);
          sent++;
        end
      end
    end

    s_tvalid = 1'b0;
    while (byte_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (fail_count == 0 && byte_expect.size() == 0) begin
      $display("metaspace_word_split_encoder_top regression: pass");
    end else begin
      $display("metaspace_word_split_encoder_top regression: fail");
    end
    $finish;
  end

endmodule
